// ===== rtl/scfb_pkg.sv =====
`timescale 1ns / 1ps

package scfb_pkg;

    localparam int MAX_BLOCKS  = 64;
    localparam int ADDR_BITS   = 48;
    localparam int SIZE_BITS   = ADDR_BITS + 1;
    localparam int SLIDE_BITS  = 64;
    localparam int COUNT_BITS  = $clog2(MAX_BLOCKS + 1);
    localparam int IN_BITS     = 2 * ADDR_BITS + SLIDE_BITS;
    localparam int IN_BYTES    = (IN_BITS + 7) / 8;
    localparam int OUT_BITS    = ADDR_BITS + SIZE_BITS + SLIDE_BITS;
    localparam int OUT_BYTES   = (OUT_BITS + 7) / 8;

    // Largest merged size: 2^ADDR_BITS
    localparam logic [SIZE_BITS-1:0] SIZE_CAP = {1'b1, {ADDR_BITS{1'b0}}};

    typedef struct packed {
        logic insert;     // take the request into the sorted store
        logic shift;      // move the store down by one entry
        logic acc_load;   // start a new head block from entry 0
        logic acc_merge;  // fold entry 0 into the head block
        logic out_load;   // move the head block to the output register
        logic flush;      // end of list: clear the drop flag
    } cmd_t;

    typedef struct packed {
        logic count_zero; // store holds no entries
        logic merge_hit;  // entry 0 continues the head block
        logic out_free;   // output register can take a result
    } status_t;

endpackage

// ===== rtl/scfb_ctrl.sv =====
`timescale 1ns / 1ps

module scfb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    input  scfb_pkg::status_t status,
    output scfb_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Accept blocks only while loading the list
    assign s_tready = (state_reg == ST_IDLE);

    // Command decode and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.insert = 1'b1;
                    if (s_tlast) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                cmd.acc_load = 1'b1;
                cmd.shift    = 1'b1;
                state_next   = ST_RUN;
            end
            ST_RUN: begin
                if (status.merge_hit) begin
                    cmd.acc_merge = 1'b1;
                    cmd.shift     = 1'b1;
                end else if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (status.count_zero) begin
                        cmd.flush  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.acc_load = 1'b1;
                        cmd.shift    = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/scfb_datapath.sv =====
`timescale 1ns / 1ps

module scfb_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic                                   cfg_wr_data,
    input  logic [scfb_pkg::ADDR_BITS-1:0]         in_addr,
    input  logic [scfb_pkg::ADDR_BITS-1:0]         in_size,
    input  logic [scfb_pkg::SLIDE_BITS-1:0]        in_slide,
    input  scfb_pkg::cmd_t                         cmd,
    output scfb_pkg::status_t                      status,
    input  logic                                   m_tready,
    output logic                                   m_tvalid,
    output logic [scfb_pkg::ADDR_BITS-1:0]         out_addr,
    output logic [scfb_pkg::SIZE_BITS-1:0]         out_size,
    output logic [scfb_pkg::SLIDE_BITS-1:0]        out_slide,
    output logic                                   out_last,
    output logic                                   out_dropped
);

    localparam int N = scfb_pkg::MAX_BLOCKS;
    localparam int AW = scfb_pkg::ADDR_BITS;
    localparam int SW = scfb_pkg::SIZE_BITS;
    localparam int LW = scfb_pkg::SLIDE_BITS;
    localparam int CW = scfb_pkg::COUNT_BITS;

    // Sorted store, one row of cells
    logic [AW-1:0] addr_reg  [N];
    logic [AW-1:0] size_reg  [N];
    logic [LW-1:0] slide_reg [N];
    logic [AW-1:0] addr_next [N];
    logic [AW-1:0] size_next [N];
    logic [LW-1:0] slide_next[N];
    logic [N-1:0]  le;

    logic [CW-1:0] count_reg;
    logic          drop_reg;
    logic          merge_en_reg;
    logic          full;
    logic          do_insert;

    // Head block being built
    logic [AW-1:0] acc_addr_reg;
    logic [SW-1:0] acc_size_reg;
    logic [LW-1:0] acc_slide_reg;
    logic [AW-1:0] gap;
    logic [SW:0]   sum;
    logic [SW-1:0] sum_sat;

    // Output register
    logic          m_valid_reg;
    logic [AW-1:0] out_addr_reg;
    logic [SW-1:0] out_size_reg;
    logic [LW-1:0] out_slide_reg;
    logic          out_last_reg;
    logic          out_drop_reg;

    assign full      = (count_reg == CW'(N));
    assign do_insert = cmd.insert && !full;

    // Per-cell compare and next value: keep, take the new block, or shift
    for (genvar k = 0; k < N; k++) begin : g_cell
        logic          prev_le;
        logic [AW-1:0] below_addr;
        logic [AW-1:0] below_size;
        logic [LW-1:0] below_slide;
        logic [AW-1:0] above_addr;
        logic [AW-1:0] above_size;
        logic [LW-1:0] above_slide;

        assign le[k] = (CW'(k) < count_reg) && (addr_reg[k] <= in_addr);

        if (k == 0) begin : g_first
            assign prev_le     = 1'b1;
            assign below_addr  = in_addr;
            assign below_size  = in_size;
            assign below_slide = in_slide;
        end else begin : g_mid
            assign prev_le     = le[k-1];
            assign below_addr  = addr_reg[k-1];
            assign below_size  = size_reg[k-1];
            assign below_slide = slide_reg[k-1];
        end

        if (k == N - 1) begin : g_last
            assign above_addr  = addr_reg[k];
            assign above_size  = size_reg[k];
            assign above_slide = slide_reg[k];
        end else begin : g_body
            assign above_addr  = addr_reg[k+1];
            assign above_size  = size_reg[k+1];
            assign above_slide = slide_reg[k+1];
        end

        always_comb begin
            addr_next[k]  = addr_reg[k];
            size_next[k]  = size_reg[k];
            slide_next[k] = slide_reg[k];
            if (do_insert && !le[k]) begin
                if (prev_le) begin
                    addr_next[k]  = in_addr;
                    size_next[k]  = in_size;
                    slide_next[k] = in_slide;
                end else begin
                    addr_next[k]  = below_addr;
                    size_next[k]  = below_size;
                    slide_next[k] = below_slide;
                end
            end else if (cmd.shift) begin
                addr_next[k]  = above_addr;
                size_next[k]  = above_size;
                slide_next[k] = above_slide;
            end
        end
    end

    // Advance the store
    always_ff @(posedge aclk) begin
        for (int k = 0; k < N; k++) begin
            addr_reg[k]  <= addr_next[k];
            size_reg[k]  <= size_next[k];
            slide_reg[k] <= slide_next[k];
        end
    end

    // Fill count, drop flag and merge enable
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            drop_reg     <= 1'b0;
            merge_en_reg <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                merge_en_reg <= cfg_wr_data;
            end
            if (do_insert) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.shift) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.insert && full) begin
                drop_reg <= 1'b1;
            end else if (cmd.flush) begin
                drop_reg <= 1'b0;
            end
        end
    end

    // Adjacency test and saturating size add against entry 0
    assign gap     = addr_reg[0] - acc_addr_reg;
    assign sum     = {1'b0, acc_size_reg} + (SW + 1)'(size_reg[0]);
    assign sum_sat = (sum > (SW + 1)'(scfb_pkg::SIZE_CAP)) ? scfb_pkg::SIZE_CAP : sum[SW-1:0];

    assign status.count_zero = (count_reg == '0);
    assign status.merge_hit  = merge_en_reg && (count_reg != '0)
                               && (slide_reg[0] == acc_slide_reg)
                               && ({1'b0, gap} == acc_size_reg);
    assign status.out_free   = !m_valid_reg || m_tready;

    // Build the head block
    always_ff @(posedge aclk) begin
        if (cmd.acc_load) begin
            acc_addr_reg  <= addr_reg[0];
            acc_size_reg  <= {1'b0, size_reg[0]};
            acc_slide_reg <= slide_reg[0];
        end else if (cmd.acc_merge) begin
            acc_size_reg  <= sum_sat;
        end
    end

    // Output register: load a result, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_addr_reg  <= acc_addr_reg;
            out_size_reg  <= acc_size_reg;
            out_slide_reg <= acc_slide_reg;
            out_last_reg  <= (count_reg == '0);
            out_drop_reg  <= drop_reg;
        end
    end

    assign m_tvalid    = m_valid_reg;
    assign out_addr    = out_addr_reg;
    assign out_size    = out_size_reg;
    assign out_slide   = out_slide_reg;
    assign out_last    = out_last_reg;
    assign out_dropped = out_drop_reg;

`ifndef SYNTHESIS
    a_shift_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift |-> (count_reg != '0))
        else $error("store shifted while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(N))
        else $error("fill count beyond capacity");

    a_sorted_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CW'(2)) |-> (addr_reg[0] <= addr_reg[1]))
        else $error("store head out of address order");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over one not yet taken");

    a_flush_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |=> (count_reg == '0) && !drop_reg)
        else $error("list state left after final result");
`endif

endmodule

// ===== rtl/sort_and_coalesce_free_blocks.sv =====
`timescale 1ns / 1ps

// Loading: one block per cycle into a sorted row of compare-and-shift cells.
// After the last block, entry 0 starts the head block; each next entry 0 is merged into
// it (single head compare/add on entry 0) or the head goes out and entry 0 starts anew.
// A result waiting on m_tready holds emission; input stalls until the last loads.
// Reset (aresetn low, synchronous): empties the store, clears the drop flag and
// output valid, sets merge_enable to 1; stored block contents are not cleared.
module sort_and_coalesce_free_blocks (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_wr_data,   // merge_enable
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // block_address [47:0], block_size [95:48], slide_value [159:96]
    input  logic [8*scfb_pkg::IN_BYTES-1:0]      s_tdata,
    input  logic                                 s_tlast,       // last_block
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_address [47:0], out_size [96:48], out_slide [160:97], zero fill above
    output logic [8*scfb_pkg::OUT_BYTES-1:0]     m_tdata,
    output logic                                 m_tlast,       // out_last
    output logic                                 m_tuser        // out_dropped
);

    localparam int AW = scfb_pkg::ADDR_BITS;
    localparam int SW = scfb_pkg::SIZE_BITS;
    localparam int LW = scfb_pkg::SLIDE_BITS;

    scfb_pkg::cmd_t    cmd;
    scfb_pkg::status_t status;

    logic [AW-1:0] out_addr;
    logic [SW-1:0] out_size;
    logic [LW-1:0] out_slide;

    scfb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    scfb_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_addr     (s_tdata[AW-1:0]),
        .in_size     (s_tdata[2*AW-1:AW]),
        .in_slide    (s_tdata[2*AW+LW-1:2*AW]),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_addr    (out_addr),
        .out_size    (out_size),
        .out_slide   (out_slide),
        .out_last    (m_tlast),
        .out_dropped (m_tuser)
    );

    // Pack the result, zero fill to whole bytes
    assign m_tdata = (8*scfb_pkg::OUT_BYTES)'({out_slide, out_size, out_addr});

endmodule
